// ----- hw/rtl/jqq_pkg.sv -----
// jqq_pkg: shared constants, tables and types for the jpeg quality quantizer
// no dependencies
package jqq_pkg;
    localparam int COEFF_W = 16;
    localparam int ENTRY_W = 8;
    localparam int QUALITY_W = 16;
    localparam int RECIP_W = 16;
    localparam int DEF_BLOCK_COEFFS = 64;
    localparam logic [15:0] QUALITY_RESET = 16'd1024;
    localparam logic [23:0] SCALE_ROUND = 24'h200;
    localparam int SCALE_SHIFT = 10;
    localparam logic [7:0] ENTRY_MAX = 8'd255;
    localparam logic [31:0] RECIP_START = 32'h8000;
    localparam logic [32:0] QUANT_ROUND = 33'h4000;
    localparam int QUANT_SHIFT = 15;
    localparam int RECIP_STEPS = 16;

    localparam logic ACT_COEFF = 1'b0;
    localparam logic ACT_REBUILD = 1'b1;
    localparam logic KIND_COEFF = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    // one queued command between front and back
    typedef struct packed {
        logic        rebuild;
        logic [15:0] value;
        logic [1:0]  comp;
        logic        flush;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] qv;
        logic [7:0]  luma;
        logic [7:0]  chroma;
        logic        last;
    } res_t;

    function automatic logic [5:0] zigzag(input logic [5:0] n);
        logic [5:0] t [64];
        t = '{6'd0, 6'd1, 6'd5, 6'd6, 6'd14, 6'd15, 6'd27, 6'd28,
              6'd2, 6'd4, 6'd7, 6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
              6'd3, 6'd8, 6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
              6'd9, 6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
              6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
              6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
              6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
              6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63};
        return t[n];
    endfunction

    function automatic logic [7:0] luma_base(input logic [5:0] n);
        logic [7:0] t [64];
        t = '{8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
              8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
              8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
              8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
              8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
              8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
              8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
              8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99};
        return t[n];
    endfunction

    function automatic logic [7:0] chroma_base(input logic [5:0] n);
        logic [7:0] r;
        r = 8'd99;
        case (n)
            6'd0: r = 8'd17;
            6'd1, 6'd8: r = 8'd18;
            6'd2, 6'd16: r = 8'd24;
            6'd3, 6'd24: r = 8'd47;
            6'd9: r = 8'd21;
            6'd10, 6'd17: r = 8'd26;
            6'd11, 6'd25: r = 8'd66;
            6'd18: r = 8'd56;
            default: r = 8'd99;
        endcase
        return r;
    endfunction
endpackage

// ----- hw/rtl/jqq_front.sv -----
// jqq_front: accepts input transfers, tracks position and component, queues commands
// depends on jqq_pkg
module jqq_front import jqq_pkg::*; #(
    parameter int BLOCK_COEFFS = DEF_BLOCK_COEFFS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,
    input  logic [15:0] s_tdata,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    localparam int PW = $clog2(BLOCK_COEFFS);
    localparam int QD = 4;
    cmd_t fifo_reg [QD];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic [PW-1:0] pos_reg;
    logic [1:0] comp_reg;
    logic push, pop;
    cmd_t c;

    assign s_tready = cnt_reg != 3'(QD);
    assign push = s_tvalid && s_tready;
    assign q_valid = cnt_reg != 3'd0;
    assign pop = q_valid && q_ready;
    assign q_cmd = fifo_reg[rp_reg];

    always_comb begin
        c.rebuild = s_tuser;
        c.value = s_tdata;
        c.comp = comp_reg;
        c.flush = pos_reg == PW'(BLOCK_COEFFS - 1);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wp_reg] <= c;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
            comp_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 2'd1;
                if (s_tuser == ACT_REBUILD) begin
                    pos_reg <= '0;
                    comp_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + PW'(1);
                    if (c.flush) begin
                        comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                    end
                end
            end
            if (pop) begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

// ----- hw/rtl/jqq_back.sv -----
// jqq_back: table rebuild with serial reciprocal, quantize, block buffer and output
// depends on jqq_pkg
module jqq_back import jqq_pkg::*; #(
    parameter int BLOCK_COEFFS = DEF_BLOCK_COEFFS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] quality,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output res_t        m_res
);
    localparam int PW = $clog2(BLOCK_COEFFS);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCALE = 3'd1, S_DIV = 3'd2,
                           S_MUL = 3'd3, S_DRAIN = 3'd4, S_RD = 3'd5;

    logic [15:0] lrec_mem [BLOCK_COEFFS];
    logic [15:0] crec_mem [BLOCK_COEFFS];
    logic [15:0] tab_mem [BLOCK_COEFFS];
    logic [15:0] blk_mem [BLOCK_COEFFS];

    logic [2:0] st_reg;
    logic [PW-1:0] idx_reg, pos_reg;
    logic [4:0] step_reg;
    logic chan_reg, kind_reg;
    logic [23:0] prod_reg;
    logic [7:0] ent_reg, lent_reg;
    logic [31:0] rem_reg, d_reg;
    logic [15:0] rec_reg, coef_reg;
    logic flush_reg;
    logic [32:0] qprod_reg;
    logic [15:0] rd_reg;
    logic rdv_reg;
    logic ov_reg;
    res_t out_reg;
    logic [13:0] sv;
    logic [7:0] ent_c;
    logic [32:0] qs;

    assign q_ready = st_reg == S_IDLE;
    assign m_tvalid = ov_reg;
    assign m_res = out_reg;
    assign sv = 14'((prod_reg + SCALE_ROUND) >> SCALE_SHIFT);
    assign ent_c = (sv == 14'd0) ? 8'd1 : (sv > 14'(ENTRY_MAX)) ? ENTRY_MAX : sv[7:0];
    assign qs = qprod_reg + QUANT_ROUND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            rdv_reg <= 1'b0;
        end else begin
            if (ov_reg && m_tready) begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        coef_reg <= q_cmd.value;
                        flush_reg <= q_cmd.flush;
                        if (q_cmd.rebuild) begin
                            idx_reg <= '0;
                            chan_reg <= 1'b0;
                            prod_reg <= 24'(luma_base('0)) * 24'(quality);
                            st_reg <= S_SCALE;
                        end else begin
                            rec_reg <= (q_cmd.comp == 2'd0) ? lrec_mem[pos_reg]
                                                            : crec_mem[pos_reg];
                            st_reg <= S_MUL;
                        end
                    end
                end
                S_SCALE: begin
                    ent_reg <= ent_c;
                    rem_reg <= RECIP_START;
                    d_reg <= 32'(ent_c) << QUANT_SHIFT;
                    step_reg <= '0;
                    st_reg <= S_DIV;
                end
                S_DIV: begin
                    if (step_reg == 5'(RECIP_STEPS)) begin
                        if (!chan_reg) begin
                            lrec_mem[idx_reg] <= rem_reg[15:0];
                            lent_reg <= ent_reg;
                            chan_reg <= 1'b1;
                            prod_reg <= 24'(chroma_base(idx_reg)) * 24'(quality);
                        end else begin
                            crec_mem[idx_reg] <= rem_reg[15:0];
                            tab_mem[zigzag(idx_reg)] <= {ent_reg, lent_reg};
                            chan_reg <= 1'b0;
                            idx_reg <= idx_reg + PW'(1);
                            prod_reg <= 24'(luma_base(idx_reg + PW'(1))) * 24'(quality);
                        end
                        if (chan_reg && idx_reg == PW'(BLOCK_COEFFS - 1)) begin
                            idx_reg <= '0;
                            pos_reg <= '0;
                            kind_reg <= KIND_TABLE;
                            st_reg <= S_DRAIN;
                        end else begin
                            st_reg <= S_SCALE;
                        end
                    end else begin
                        if (rem_reg > d_reg) begin
                            rem_reg <= ((rem_reg - d_reg) << 1) + 32'd1;
                        end else begin
                            rem_reg <= rem_reg << 1;
                        end
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_MUL: begin
                    qprod_reg <= 33'($signed(coef_reg) * $signed({1'b0, rec_reg}));
                    st_reg <= S_RD;
                end
                S_RD: begin
                    blk_mem[zigzag(pos_reg)] <= qs[QUANT_SHIFT +: 16];
                    pos_reg <= pos_reg + PW'(1);
                    if (flush_reg) begin
                        idx_reg <= '0;
                        kind_reg <= KIND_COEFF;
                        st_reg <= S_DRAIN;
                    end else begin
                        st_reg <= S_IDLE;
                    end
                end
                S_DRAIN: begin
                    if (!rdv_reg) begin
                        rd_reg <= (kind_reg == KIND_TABLE) ? tab_mem[idx_reg]
                                                           : blk_mem[idx_reg];
                        rdv_reg <= 1'b1;
                    end else if (!ov_reg || m_tready) begin
                        ov_reg <= 1'b1;
                        out_reg.kind <= kind_reg;
                        out_reg.qv <= (kind_reg == KIND_TABLE) ? 16'd0 : rd_reg;
                        out_reg.luma <= (kind_reg == KIND_TABLE) ? rd_reg[7:0] : 8'd0;
                        out_reg.chroma <= (kind_reg == KIND_TABLE) ? rd_reg[15:8] : 8'd0;
                        out_reg.last <= idx_reg == PW'(BLOCK_COEFFS - 1);
                        rdv_reg <= 1'b0;
                        idx_reg <= idx_reg + PW'(1);
                        if (idx_reg == PW'(BLOCK_COEFFS - 1)) begin
                            st_reg <= S_IDLE;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/jpeg_quality_quantizer.sv -----
// jpeg_quality_quantizer: top level, quality register, front and back
// depends on jqq_pkg, jqq_front, jqq_back
// coefficient: back states S_IDLE, S_MUL, S_RD; each 64th starts a drain of the block
// rebuild: S_SCALE and serial reciprocal S_DIV for 64 entries x 2 tables, then a drain
// the back takes a new command only in S_IDLE, after the multiply sequence of the last one
// reset: synchronous active-low aresetn clears control, quality_reg returns to 1024
module jpeg_quality_quantizer import jqq_pkg::*; #(
    parameter int BLOCK_COEFFS = DEF_BLOCK_COEFFS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // action
    input  logic [15:0] s_tdata,    // coefficient
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,    // kind
    output logic        m_tlast,
    output logic [31:0] m_tdata     // quantized_value, luma_entry, chroma_entry
);
    logic [15:0] quality_reg;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_reg <= QUALITY_RESET;
        end else if (cfg_valid) begin
            quality_reg <= cfg_data;
        end
    end

    jqq_front #(.BLOCK_COEFFS(BLOCK_COEFFS)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    jqq_back #(.BLOCK_COEFFS(BLOCK_COEFFS)) u_back (
        .aclk, .aresetn, .quality(quality_reg), .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_res(res)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {res.chroma, res.luma, res.qv};
endmodule

// ----- hw/rtl/jqq_checker.sv -----
// jqq_assertions: port-level assertions for jpeg_quality_quantizer, bound to the top
// depends on jpeg_quality_quantizer ports
module jqq_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled output changed");
    a_tab_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[15:0] == 16'd0 && m_tdata[7+16:16] != 8'd0)
        else $error("table transfer malformed");
    a_coef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'd0)
        else $error("coefficient transfer has entries");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind jpeg_quality_quantizer jqq_assertions u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tuser, .m_tlast, .m_tdata
);
